// File: rtl/core/bdq_pkg.sv
package bdq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned FILL_W = 5;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;

  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_NOP        = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr_front;
    logic [PTR_W-1:0]  raddr_back;
  } ram_req_t;

  typedef struct packed {
    logic             load;
    logic             ok;
    logic [CNT_W-1:0] count;
  } rsp_ctl_t;

  // ptr < DEPTH and off < DEPTH, so one conditional subtract wraps the sum
  function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] ptr,
                                                logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(ptr) + SUM_W'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// File: rtl/core/bdq_if.sv
interface bdq_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [bdq_pkg::CMD_W-1:0]           command;
  logic signed [bdq_pkg::DATA_W-1:0]   value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface bdq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [bdq_pkg::DATA_W-1:0]   front_value;
  logic signed [bdq_pkg::DATA_W-1:0]   back_value;
  logic [bdq_pkg::FILL_W-1:0]          fill_count;

  modport source (output valid, ok, front_value, back_value, fill_count, input ready);
  modport sink   (input valid, ok, front_value, back_value, fill_count, output ready);
endinterface

// File: rtl/core/bdq_ram.sv
module bdq_ram #(
  parameter int unsigned Depth  = 16,
  parameter int unsigned Width  = 32,
  parameter int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// File: rtl/core/bdq_ctrl.sv
module bdq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  logic [bdq_pkg::CMD_W-1:0] cmd_command_i,
  input  logic [bdq_pkg::DATA_W-1:0] cmd_value_i,
  output logic                      cmd_ready_o,
  input  logic                      out_free_i,
  output bdq_pkg::ram_req_t         ram_req_o,
  output bdq_pkg::rsp_ctl_t         rsp_ctl_o
);
  import bdq_pkg::*;

  state_e           state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ok_q, ok_d;
  logic             full, empty, accept;

  assign full   = (count_q == DEPTH_C);
  assign empty  = (count_q == '0);
  assign accept = cmd_valid_i && cmd_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    ok_d        = ok_q;
    cmd_ready_o = 1'b0;
    ram_req_o   = '0;
    ram_req_o.wdata = cmd_value_i;
    rsp_ctl_o.load  = 1'b0;
    rsp_ctl_o.ok    = ok_q;
    rsp_ctl_o.count = count_q;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (accept) begin
          state_d = ST_READ;
          ok_d    = 1'b1;
          unique case (cmd_command_i)
            CMD_PUSH_BACK: begin
              if (full) begin
                ok_d = 1'b0;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = ring_add(head_q, count_q);
                count_d         = count_q + 1'b1;
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                ok_d = 1'b0;
              end else begin
                head_d          = (head_q == '0) ? PTR_LAST : head_q - 1'b1;
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = head_d;
                count_d         = count_q + 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                ok_d = 1'b0;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                ok_d = 1'b0;
              end else begin
                head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
                count_d = count_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ram_req_o.re          = 1'b1;
        ram_req_o.raddr_front = head_q;
        ram_req_o.raddr_back  = empty ? head_q : ring_add(head_q, count_q - 1'b1);
        state_d               = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free_i) begin
          rsp_ctl_o.load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/bounded_double_ended_queue_core.sv
// Double-ended queue of 32-bit signed values, DEPTH entries in a ring buffer.
// Command channel (cmd_i): command 0 push back, 1 push front, 2 pop back,
// 3 pop front, anything else no change; value is the element for pushes.
// Response channel (rsp_o): one beat per command with ok (0 when a push finds
// the queue full or a pop finds it empty), front_value and back_value after
// the command (0 when empty) and fill_count.
// Timing: a command is taken in the idle state and the entry memory is written
// on that edge; both ends are read in the next cycle into the memory's read
// registers, and the load state then copies the read data into the output
// register. No new command is taken until the write, read and load steps of
// the current one are through.
// Stalls: the output register holds a finished response while rsp_o.ready is
// low; the next command is still taken and read, then waits in its load stage
// with the read data until the output register frees up. No further command
// is taken meanwhile.
// Reset: the queue comes up empty with the head at slot 0. Entries are not
// cleared; only written entries are ever read out, so no clearing pass runs.
module bounded_double_ended_queue_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_cmd_if.sink   cmd_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  ram_req_t          ram_req;
  rsp_ctl_t          rsp_ctl;
  logic [DATA_W-1:0] rdata_front, rdata_back;
  logic              out_valid_q;
  logic              out_ok_q;
  logic [DATA_W-1:0] out_front_q, out_back_q;
  logic [FILL_W-1:0] out_fill_q;
  logic              out_free;

  assign out_free = !out_valid_q || rsp_o.ready;

  bdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_i.valid),
    .cmd_command_i(cmd_i.command),
    .cmd_value_i  (cmd_i.value),
    .cmd_ready_o  (cmd_i.ready),
    .out_free_i   (out_free),
    .ram_req_o    (ram_req),
    .rsp_ctl_o    (rsp_ctl)
  );

  bdq_ram #(
    .Depth(DEPTH),
    .Width(DATA_W),
    .AddrW(PTR_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_req.we),
    .waddr_i  (ram_req.waddr),
    .wdata_i  (ram_req.wdata),
    .re_i     (ram_req.re),
    .raddr_a_i(ram_req.raddr_front),
    .raddr_b_i(ram_req.raddr_back),
    .rdata_a_o(rdata_front),
    .rdata_b_o(rdata_back)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ctl.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ctl.load) begin
      out_ok_q    <= rsp_ctl.ok;
      out_front_q <= (rsp_ctl.count == '0) ? '0 : rdata_front;
      out_back_q  <= (rsp_ctl.count == '0) ? '0 : rdata_back;
      out_fill_q  <= FILL_W'(rsp_ctl.count);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_ok_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.fill_count  = out_fill_q;

endmodule

// File: rtl/core/bdq_checker.sv
module bdq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_ok_i,
  input logic [bdq_pkg::DATA_W-1:0] rsp_front_i,
  input logic [bdq_pkg::DATA_W-1:0] rsp_back_i,
  input logic [bdq_pkg::FILL_W-1:0] rsp_fill_i
);
  import bdq_pkg::*;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

  a_empty_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_fill_i == '0) |-> (rsp_front_i == '0) && (rsp_back_i == '0))
    else $error("empty queue reports nonzero ends");

  a_single_same_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_fill_i == FILL_W'(1)) |-> rsp_front_i == rsp_back_i)
    else $error("single element but front and back differ");

  a_refuse_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |-> (rsp_fill_i == '0) || (rsp_fill_i == FILL_FULL))
    else $error("refusal while neither empty nor full");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_ok_i)
      && $stable(rsp_front_i) && $stable(rsp_back_i) && $stable(rsp_fill_i))
    else $error("stalled response beat changed");

endmodule

bind bounded_double_ended_queue_core bdq_checker u_bdq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .rsp_ok_i   (rsp_o.ok),
  .rsp_front_i(rsp_o.front_value),
  .rsp_back_i (rsp_o.back_value),
  .rsp_fill_i (rsp_o.fill_count)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bdq_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [FILL_W-1:0]        fill_count;
  } deque_view_t;

  class deque_scoreboard;
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned head;
    int unsigned count;
    deque_view_t expected_views [$];
    int errors;
    int checked;
    int refused;
    int full_hits;
    int cmd_counts [8];

    function new();
      head = 0;
      count = 0;
      errors = 0;
      checked = 0;
      refused = 0;
      full_hits = 0;
      foreach (cmd_counts[i]) cmd_counts[i] = 0;
    endfunction

    function int pending();
      return expected_views.size();
    endfunction

    // Apply one accepted command to the shadow deque and queue the view it yields.
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
      deque_view_t view;
      view.ok = 1'b1;
      view.front_value = '0;
      view.back_value = '0;
      cmd_counts[cmd]++;
      case (cmd)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            view.ok = 1'b0;
          end else if (cmd == CMD_PUSH_BACK) begin
            slots[(head + count) % DEPTH] = value;
            count++;
          end else begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = value;
            count++;
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (count == 0) begin
            view.ok = 1'b0;
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              head = (head + 1) % DEPTH;
            end
            count--;
          end
        end
        default: ;
      endcase
      if (count != 0) begin
        view.front_value = slots[head];
        view.back_value = slots[(head + count - 1) % DEPTH];
      end
      if (!view.ok) refused++;
      if (count == DEPTH) full_hits++;
      view.fill_count = FILL_W'(count);
      expected_views.insert(expected_views.size(), view);
    endfunction

    function void check_response(deque_view_t got);
      deque_view_t want;
      if (expected_views.size() == 0) begin
        $error("response beat with no command outstanding");
        errors++;
        return;
      end
      want = expected_views[0];
      expected_views.delete(0);
      checked++;
      if (got.ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, got.ok);
        errors++;
      end
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %0d, got %0d", want.front_value, got.front_value);
        errors++;
      end
      if (got.back_value !== want.back_value) begin
        $error("back_value: expected %0d, got %0d", want.back_value, got.back_value);
        errors++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bdq_cmd_if cmd_if ();
  bdq_rsp_if rsp_if ();

  bounded_double_ended_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  deque_scoreboard sb = new();
  int sent_beats = 0;
  int taken_beats = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Quiet stretches with no idling, otherwise a random idle wait between beats.
  function automatic int idle_cycles(int beat_idx);
    if ((beat_idx / 40) % 4 == 1) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] value);
    int gap;
    gap = idle_cycles(sent_beats);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.value   <= value;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.note_command(cmd, value);
    sent_beats++;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int n);
    int bias;
    int run_left;
    int push_pct;
    logic [CMD_W-1:0] cmd;
    bias = 0;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        bias = $urandom_range(0, 2);
        run_left = $urandom_range(8, 48);
      end
      run_left--;
      push_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
      if ($urandom_range(0, 99) < 5) begin
        cmd = CMD_W'($urandom_range(4, 7));
      end else if ($urandom_range(0, 99) < push_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else begin
        cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_command(cmd, pick_value());
      if (i == n / 2) begin
        // hold the command side until every response is back
        cmd_if.valid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  // response side: random stalls, check every beat
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_cycles(taken_beats);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      sb.check_response('{rsp_if.ok, rsp_if.front_value, rsp_if.back_value,
                          rsp_if.fill_count});
      taken_beats++;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("bounded_double_ended_queue_core test failed");
    $finish;
  end

  initial begin
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= CMD_NOP;
    cmd_if.value   <= '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, every no-change code
    send_command(CMD_POP_BACK, 32'sd5);
    send_command(CMD_POP_FRONT, -32'sd5);
    send_command(CMD_NOP, 32'sh7fffffff);
    send_command(CMD_W'(5), '0);
    send_command(CMD_W'(6), '0);
    send_command(CMD_W'(7), -32'sd1);
    // fill to the top, front pushes wrap the head below slot 0
    send_command(CMD_PUSH_FRONT, 32'sh80000000);
    send_command(CMD_PUSH_BACK, 32'sh7fffffff);
    for (int i = 0; i < 14; i++) begin
      send_command((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                   (i % 3 == 0) ? -32'sd1 : pick_value());
    end
    send_command(CMD_PUSH_BACK, 32'sd1);
    send_command(CMD_PUSH_FRONT, 32'sd2);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
    cmd_if.valid <= 1'b0;
    wait_drained();

    run_random(1400);
    cmd_if.valid <= 1'b0;
    wait_drained();
    repeat (12) @(posedge clk_i);

    $display("%0d commands: push back %0d, push front %0d, pop back %0d, pop front %0d",
             sent_beats, sb.cmd_counts[CMD_PUSH_BACK], sb.cmd_counts[CMD_PUSH_FRONT],
             sb.cmd_counts[CMD_POP_BACK], sb.cmd_counts[CMD_POP_FRONT]);
    $display("%0d responses checked, %0d refused, %0d left the deque full",
             sb.checked, sb.refused, sb.full_hits);
    if (sb.errors == 0) begin
      $display("bounded_double_ended_queue_core test passed");
    end else begin
      $display("bounded_double_ended_queue_core test failed");
    end
    $finish;
  end

endmodule
